FILE: rtl/mwo_pkg.sv
// Package: shared constants, codes and the quarter-wave sine table builder.
`timescale 1ns / 1ps

package mwo_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Sine table geometry: full wave index width and quarter-wave depth.
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
  localparam int SINE_QDEPTH    = SINE_DEPTH / 4;
  localparam int SINE_QIDX_BITS = $clog2(SINE_QDEPTH + 1);
  localparam int SINE_ENTRY_W   = 24;

  localparam logic [31:0] NOISE_SEED  = 32'hACE1_2468;
  localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PHASE_INC = 2'd0,
    REG_WAVEFORM  = 2'd1,
    REG_GAIN      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    WAVE_NOISE    = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_SAWTOOTH = 3'd4
  } wave_t;

  localparam logic [2:0]  WAVE_RST = 3'd1;
  localparam logic [15:0] GAIN_RST = 16'd32768;

  typedef logic [SINE_ENTRY_W-1:0] sine_qtab_t [0:SINE_QDEPTH];

  // Taylor term divisors (2k)(2k+1), k = 1..7.
  function automatic longint unsigned taylor_div(longint unsigned v, int k);
    case (k)
      1: return v / 64'd6;
      2: return v / 64'd20;
      3: return v / 64'd42;
      4: return v / 64'd72;
      5: return v / 64'd110;
      6: return v / 64'd156;
      default: return v / 64'd210;
    endcase
  endfunction

  // Quarter wave, entry q holds round(sin(q/QDEPTH * pi/2) * (2^(sbits-1)-1)).
  // Evaluated at elaboration only.
  function automatic sine_qtab_t build_sine_qtab(int sbits);
    sine_qtab_t      tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned smax;
    longint unsigned v;
    longint          sum;
    smax = (64'd1 << (sbits - 1)) - 64'd1;
    for (int q = 0; q <= SINE_QDEPTH; q++) begin
      x    = (64'(4 * q) * HALF_PI_Q30) / 64'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = taylor_div((term * x2) >> 30, k);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) * smax + (64'd1 << 29)) >> 30;
      if (v > smax) begin
        v = smax;
      end
      tab[q] = SINE_ENTRY_W'(v);
    end
    return tab;
  endfunction

endpackage

FILE: rtl/multi_waveform_oscillator_top.sv
// Top level: DDS oscillator with APB config, phase/LFSR state and two-register datapath.
`timescale 1ns / 1ps

//  channel  | ports                               | transfer when
//  ---------+-------------------------------------+------------------------------
//  input    | in_valid in_ready in_sample_tick    | in_valid & in_ready
//  result   | out_valid out_ready out_sample_out  | out_valid & out_ready
//  config   | psel penable pwrite paddr pwdata    | psel & penable & pwrite
//
// One sample per cycle unless out_ready stalls; ticks pass capture then output register.
// Path: capture register (phase, stepped LFSR) -> waveform select, 257-entry quarter-sine
// lookup, one gain multiply, saturate -> output register.
// A transfer with in_sample_tick low is taken but yields no sample and no state change.
// rst_n is synchronous; phase clears, LFSR loads its seed, registers take reset values.
// A stalled output holds the capture stage; in_ready drops only when both stages are full.

module multi_waveform_oscillator_top
  import mwo_pkg::*;
#(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_sample_tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam int S      = SAMPLE_BITS;
  localparam int UNITY  = 1 << (S - 1);
  localparam int EXT_W  = PHASE_BITS + S + 1;
  localparam sine_qtab_t SINE_QTAB = build_sine_qtab(SAMPLE_BITS);
  localparam logic signed [S+1:0] SAT_HI = (S+2)'(UNITY - 1);
  localparam logic signed [S+1:0] SAT_LO = -((S+2)'(UNITY));

  // configuration registers
  logic [31:0] phase_inc_r;
  logic [2:0]  waveform_r;
  logic [15:0] gain_r;
  logic        cfg_wr;

  // oscillator state
  logic [PHASE_BITS-1:0] phase_r;
  logic [31:0]           lfsr_r;
  logic [31:0]           lfsr_nxt;

  // capture stage
  logic                  a_valid_r;
  logic [PHASE_BITS-1:0] a_phase_r;
  logic [31:0]           a_noise_r;

  // output stage
  logic                  out_valid_r;
  logic signed [S-1:0]   out_sample_r;

  logic in_fire;
  logic tick_fire;
  logic out_adv;
  logic a_adv;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      waveform_r  <= WAVE_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PHASE_INC: phase_inc_r <= pwdata;
        REG_WAVEFORM:  waveform_r  <= pwdata[2:0];
        REG_GAIN:      gain_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PHASE_INC: prdata = phase_inc_r;
      REG_WAVEFORM:  prdata = {29'd0, waveform_r};
      REG_GAIN:      prdata = {16'd0, gain_r};
      default:       prdata = '0;
    endcase
  end

  // handshake
  assign out_adv   = !out_valid_r || out_ready;
  assign a_adv     = !a_valid_r || out_adv;
  assign in_ready  = a_adv;
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && in_sample_tick;

  // Galois LFSR, one step per tick
  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      lfsr_r  <= NOISE_SEED;
    end else if (tick_fire) begin
      phase_r <= phase_r + PHASE_BITS'(phase_inc_r);
      lfsr_r  <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= tick_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && tick_fire) begin
      a_phase_r <= phase_r;
      a_noise_r <= lfsr_nxt;
    end
  end

  // waveform generation
  logic [EXT_W-1:0]           phase_ext;
  logic [SINE_IDX_BITS-1:0]   sine_idx;
  logic [SINE_QIDX_BITS-1:0]  sine_q;
  logic [S-1:0]               sine_mag;
  logic signed [S:0]          w_sine;
  logic [S:0]                 tri_top;
  logic signed [S+1:0]        tri_diff;
  logic signed [S+1:0]        tri_abs;
  logic signed [S:0]          w_tri;
  logic signed [S:0]          w_saw;
  logic signed [S:0]          w_noise;
  logic signed [S:0]          w_sq;
  logic signed [S:0]          w_sel;
  logic signed [S+16:0]       prod;
  logic signed [S+1:0]        scaled;
  logic signed [S-1:0]        sat;

  // phase scaled to any top width, zero filled below when the phase is short
  assign phase_ext = {a_phase_r, {(S + 1){1'b0}}};

  assign sine_idx = a_phase_r[PHASE_BITS-1 -: SINE_IDX_BITS];
  // odd quadrants read the quarter table backwards
  assign sine_q   = sine_idx[SINE_IDX_BITS-2]
                    ? SINE_QIDX_BITS'(SINE_QDEPTH) - SINE_QIDX_BITS'(sine_idx[SINE_IDX_BITS-3:0])
                    : SINE_QIDX_BITS'(sine_idx[SINE_IDX_BITS-3:0]);
  assign sine_mag = SINE_QTAB[sine_q][S-1:0];
  assign w_sine   = sine_idx[SINE_IDX_BITS-1] ? -$signed({1'b0, sine_mag})
                                              : $signed({1'b0, sine_mag});

  assign tri_top  = phase_ext[EXT_W-1 -: S+1];
  assign tri_diff = $signed({1'b0, tri_top}) - $signed((S+2)'(2 * UNITY));
  assign tri_abs  = (tri_diff < 0) ? -tri_diff : tri_diff;
  assign w_tri    = (S+1)'(tri_abs - $signed((S+2)'(UNITY)));

  assign w_saw   = $signed({1'b0, phase_ext[EXT_W-1 -: S]}) - $signed((S+1)'(UNITY));
  assign w_noise = $signed({1'b0, a_noise_r[31 -: S]}) - $signed((S+1)'(UNITY));
  assign w_sq    = a_phase_r[PHASE_BITS-1] ? -$signed((S+1)'(UNITY)) : $signed((S+1)'(UNITY));

  always_comb begin
    case (waveform_r)
      WAVE_NOISE:    w_sel = w_noise;
      WAVE_SINE:     w_sel = w_sine;
      WAVE_TRIANGLE: w_sel = w_tri;
      WAVE_SQUARE:   w_sel = w_sq;
      WAVE_SAWTOOTH: w_sel = w_saw;
      default:       w_sel = '0;
    endcase
  end

  // gain is Q1.15; floor shift then clamp
  assign prod   = w_sel * $signed({1'b0, gain_r});
  assign scaled = prod[S+16:15];
  assign sat    = (scaled > SAT_HI) ? SAT_HI[S-1:0] :
                  (scaled < SAT_LO) ? SAT_LO[S-1:0] : scaled[S-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid_r) begin
      out_sample_r <= sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // the LFSR must never lock up at zero
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 32'd0)
    else $error("noise LFSR reached zero");

  // phase and LFSR only move on a tick transfer
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_fire |=> $stable(phase_r) && $stable(lfsr_r))
    else $error("oscillator state changed without a tick");

  // a captured tick waits while the output is stalled
  a_capture_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && out_valid_r && !out_ready) |=> a_valid_r && $stable(a_phase_r))
    else $error("capture stage lost an item under stall");

endmodule

FILE: verif/mwo_sample_checker.sv
// Sample checker: tracks oscillator state from the ports, predicts each sample and compares.
`timescale 1ns / 1ps

module mwo_sample_checker
  import mwo_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_sample_tick,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0] out_sample_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [CFG_ADDR_W-1:0]             paddr,
  input  logic [CFG_DATA_W-1:0]             pwdata,
  output int                                mismatches,
  output int                                samples_owed
);

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int PW = PHASE_BITS_DEF;
  localparam longint UNITY  = longint'(1) << (SW - 1);
  localparam longint SAT_HI = UNITY - 1;
  localparam longint SAT_LO = -UNITY;
  localparam int TABLE_DEPTH = 1024;
  localparam int TABLE_BITS  = 10;
  localparam logic [31:0] LFSR_SEED = 32'hACE1_2468;
  localparam logic [31:0] LFSR_POLY = 32'h8020_0003;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  logic [PW-1:0]        phase_acc;
  logic [31:0]          noise_lfsr;
  logic [31:0]          tuning_word;
  logic [2:0]           wave_sel;
  logic [15:0]          gain_q15;
  logic signed [SW-1:0] pending_samples [$];
  longint               sine_wave [TABLE_DEPTH];

  // Full-wave table from a Q30 Taylor series on the folded quarter wave.
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned quad;
    longint unsigned offs;
    longint          acc;
    longint          mag;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      quad = (longint'(i) * 4) / TABLE_DEPTH;
      offs = (longint'(i) * 4) % TABLE_DEPTH;
      if (quad[0]) begin
        offs = TABLE_DEPTH - offs;
      end
      x    = (offs * QUARTER_TURN_Q30) / TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      mag = (acc * SAT_HI + (longint'(1) << 29)) >>> 30;
      if (mag > SAT_HI) begin
        mag = SAT_HI;
      end
      sine_wave[i] = quad[1] ? -mag : mag;
    end
  end

  function automatic logic signed [SW-1:0] next_sample(input logic [2:0]  wave,
                                                       input logic [PW-1:0] ph,
                                                       input logic [31:0] lfsr,
                                                       input logic [15:0] g);
    longint level;
    longint tri_dist;
    longint scaled;
    case (wave)
      WAVE_NOISE:    level = longint'(lfsr[31 -: SW]) - UNITY;
      WAVE_SINE:     level = sine_wave[ph[PW-1 -: TABLE_BITS]];
      WAVE_TRIANGLE: begin
        tri_dist = longint'(ph[PW-1 -: SW+1]) - 2 * UNITY;
        if (tri_dist < 0) begin
          tri_dist = -tri_dist;
        end
        level = tri_dist - UNITY;
      end
      WAVE_SQUARE:   level = ph[PW-1] ? -UNITY : UNITY;
      WAVE_SAWTOOTH: level = longint'(ph[PW-1 -: SW]) - UNITY;
      default:       level = 0;
    endcase
    // floor division by 2^15, then clip to the sample range
    scaled = (level * longint'(g)) >>> 15;
    if (scaled > SAT_HI) begin
      scaled = SAT_HI;
    end
    if (scaled < SAT_LO) begin
      scaled = SAT_LO;
    end
    return SW'(scaled);
  endfunction

  always @(posedge clk) begin : track
    logic signed [SW-1:0] want;
    if (!rst_n) begin
      phase_acc   = '0;
      noise_lfsr  = LFSR_SEED;
      tuning_word = '0;
      wave_sel    = WAVE_SINE;
      gain_q15    = 16'd32768;
      pending_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_PHASE_INC: tuning_word = pwdata[31:0];
          REG_WAVEFORM:  wave_sel    = pwdata[2:0];
          REG_GAIN:      gain_q15    = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) begin
          $error("out_sample_out: no sample expected, actual %0d", out_sample_out);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_samples.pop_front();
          if (out_sample_out !== want) begin
            $error("out_sample_out: expected %0d, actual %0d", want, out_sample_out);
            mismatches <= mismatches + 1;
          end
        end
      end
      // LFSR steps on every tick, then the sample uses the pre-advance phase
      if (in_valid && in_ready && in_sample_tick) begin
        noise_lfsr = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? LFSR_POLY : 32'h0);
        pending_samples.push_back(next_sample(wave_sel, phase_acc, noise_lfsr, gain_q15));
        phase_acc = phase_acc + PW'(tuning_word);
      end
    end
    samples_owed <= pending_samples.size();
  end

endmodule

FILE: verif/multi_waveform_oscillator_top_test.sv
// Testbench top: drives ticks, register writes and output stalls, then reports the verdict.
`timescale 1ns / 1ps

module multi_waveform_oscillator_top_test;
  import mwo_pkg::*;

  localparam int SW           = SAMPLE_BITS_DEF;
  localparam int ITEM_TARGET  = 750;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = CFG_ADDR_W'((int'(REG_GAIN) + 1) * 4);

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_sample_tick;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [SW-1:0] out_sample_out;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                 pready;
  int                   mismatches;
  int                   samples_owed;
  int                   cycle_count;

  multi_waveform_oscillator_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_tick (in_sample_tick),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  mwo_sample_checker sample_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_tick (in_sample_tick),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches     (mismatches),
    .samples_owed   (samples_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: ready bursts and stalls of mixed length, with some long open stretches.
  initial begin
    int  span;
    int  pick;
    logic level;
    out_ready = 1'b0;
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        level = 1'b1;
        span  = $urandom_range(1, 8);
      end else if (pick < 8) begin
        level = 1'b0;
        span  = $urandom_range(1, 3);
      end else if (pick == 8) begin
        level = 1'b1;
        span  = $urandom_range(50, 150);
      end else begin
        level = 1'b0;
        span  = $urandom_range(10, 40);
      end
      @(negedge clk);
      out_ready <= level;
      repeat (span - 1) @(negedge clk);
    end
  end

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input reg_idx_t idx);
    return CFG_ADDR_W'(int'(idx) * 4);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds valid high across back-to-back transfers; drops it only for a gap.
  task automatic push_tick(input logic tick, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_sample_tick <= tick;
    do @(posedge clk); while (!in_ready);
  endtask

  // Idle point: no tick pending, every sample back, pipeline drained.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (samples_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic pick_config();
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       write_reg(reg_addr(REG_PHASE_INC), 32'h0);
        1:       write_reg(reg_addr(REG_PHASE_INC), 32'hFFFF_FFFF);
        2:       write_reg(reg_addr(REG_PHASE_INC), 32'h8000_0000);
        3:       write_reg(reg_addr(REG_PHASE_INC), $urandom_range(1, 65535));
        default: write_reg(reg_addr(REG_PHASE_INC), $urandom);
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 9) < 8) begin
        write_reg(reg_addr(REG_WAVEFORM), $urandom_range(WAVE_NOISE, WAVE_SAWTOOTH));
      end else begin
        // unassigned waveform codes
        write_reg(reg_addr(REG_WAVEFORM), $urandom_range(int'(WAVE_SAWTOOTH) + 1, 7));
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0:       write_reg(reg_addr(REG_GAIN), 32'd0);
        1:       write_reg(reg_addr(REG_GAIN), 32'd32768);
        2:       write_reg(reg_addr(REG_GAIN), 32'd65535);
        3:       write_reg(reg_addr(REG_GAIN), $urandom_range(0, 32768));
        default: write_reg(reg_addr(REG_GAIN), $urandom_range(0, 65535));
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(UNMAPPED_ADDR, $urandom);
    end
  endtask

  initial begin
    int   items_sent;
    int   burst_len;
    bit   no_gaps;
    logic tick;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample_tick = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    items_sent     = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: sine at phase zero, plus a tick-low transfer in between.
    push_tick(1'b1, 0);
    push_tick(1'b0, 0);
    push_tick(1'b1, 1);
    settle();

    // Triangle peak at phase zero saturates; max tuning word wraps backwards.
    write_reg(reg_addr(REG_PHASE_INC), 32'hFFFF_FFFF);
    write_reg(reg_addr(REG_WAVEFORM), WAVE_TRIANGLE);
    write_reg(reg_addr(REG_GAIN), 32'd65535);
    repeat (3) push_tick(1'b1, 0);
    settle();

    // Half-cycle steps through every waveform code and the gain extremes.
    write_reg(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    write_reg(reg_addr(REG_PHASE_INC), 32'h8000_0000);
    for (int code = 0; code < 8; code++) begin
      write_reg(reg_addr(REG_WAVEFORM), code);
      case (code % 3)
        0:       write_reg(reg_addr(REG_GAIN), 32'd32768);
        1:       write_reg(reg_addr(REG_GAIN), 32'd65535);
        default: write_reg(reg_addr(REG_GAIN), 32'd0);
      endcase
      push_tick(1'b1, 0);
      push_tick(1'b1, code % 2);
      settle();
    end

    while (items_sent < ITEM_TARGET) begin
      pick_config();
      burst_len = $urandom_range(5, 60);
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < burst_len; n++) begin
        tick = ($urandom_range(0, 9) != 0);
        push_tick(tick, no_gaps ? 0 : pick_gap());
        items_sent++;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
